FILE: design/madt_interrupt_route_table_macros.svh
// Assertion macros shared by the checker.
`ifndef MADT_INTERRUPT_ROUTE_TABLE_MACROS_SVH
`define MADT_INTERRUPT_ROUTE_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MADT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define MADT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/madt_pkg.sv
`default_nettype none
package madt_pkg;
   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_IO_RD  = 2'd1;
   localparam logic [1:0] OP_OVR_RD = 2'd2;
   localparam logic [1:0] OP_ISA    = 2'd3;

   localparam logic [7:0] REC_CPU   = 8'd0;
   localparam logic [7:0] REC_IO    = 8'd1;
   localparam logic [7:0] REC_OVR   = 8'd2;
   localparam logic [7:0] REC_NMI   = 8'd3;
   localparam logic [7:0] REC_LNMI  = 8'd4;
   localparam logic [7:0] REC_LADDR = 8'd5;

   localparam int REC_BUF = 12;
   localparam logic [15:0] TALLY_MAX = 16'hffff;

   // Tallies and address override, shown in every result.
   typedef struct packed {
      logic [15:0] cpu_total;
      logic [15:0] io_total;
      logic [15:0] override_count;
      logic [15:0] nmi_total;
      logic        lapic_override_present;
      logic [63:0] lapic_override_address;
   } summary_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == TALLY_MAX) ? v : v + 16'd1;
   endfunction
endpackage
`default_nettype wire

FILE: design/madt_parser.sv
`default_nettype none
// Record assembler: one table byte per call, builds a record in a small
// register buffer and pulses rec_done with the finished record.
module madt_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  byte_data,
   input  wire logic        byte_last,
   input  wire logic        clear,
   output logic             rec_done,
   output logic [95:0]      rec_bytes,
   output logic [7:0]       rec_len
);
   import madt_pkg::*;
   logic [7:0] buf_ff [REC_BUF];
   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic       stop_ff, stop_in;
   logic       done;

   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      stop_in = stop_ff;
      done = 1'b0;
      if (clear) begin
         pos_in = 8'd0;
         len_in = 8'd0;
         stop_in = 1'b0;
      end
      if (byte_valid && !(stop_in)) begin
         if (pos_in == 8'd0) begin
            pos_in = 8'd1;
         end else if (pos_in == 8'd1) begin
            len_in = byte_data;
            if (byte_data < 8'd2) begin
               stop_in = 1'b1;
            end else if (byte_data == 8'd2) begin
               done = 1'b1;
               pos_in = 8'd0;
            end else begin
               pos_in = 8'd2;
            end
         end else begin
            pos_in = pos_in + 8'd1;
            if (pos_in >= len_in) begin
               done = 1'b1;
               pos_in = 8'd0;
            end
         end
      end
      if (byte_valid && byte_last) begin
         pos_in = 8'd0;
         stop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
         len_ff <= 8'd0;
         stop_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         stop_ff <= stop_in;
      end
   end

   // Buffer write uses the position before this byte.
   logic [7:0] wpos;
   assign wpos = clear ? 8'd0 : pos_ff;
   always_ff @(posedge clock) begin
      if (byte_valid && !(stop_ff && !clear) && wpos < 8'(REC_BUF))
         buf_ff[wpos[3:0]] <= byte_data;
   end

   // The finishing byte is merged into the record view.
   always_comb begin
      for (int i = 0; i < REC_BUF; i++) begin
         rec_bytes[i*8 +: 8] = (wpos == 8'(i)) ? byte_data : buf_ff[i];
      end
   end
   assign rec_done = done;
   assign rec_len = (wpos == 8'd1) ? byte_data : len_ff;
endmodule
`default_nettype wire

FILE: design/madt_route_store.sv
`default_nettype none
// Route memories: io controller routes and override routes, one port each,
// registered reads.
module madt_route_store #(
   parameter int IOAPIC_SLOTS = 8,
   parameter int OVERRIDE_SLOTS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              io_we,
   input  wire logic [$clog2(IOAPIC_SLOTS+1)-1:0] io_addr,
   input  wire logic [71:0]                       io_wdata,
   output logic      [71:0]                       io_rdata,
   input  wire logic                              ov_we,
   input  wire logic [$clog2(OVERRIDE_SLOTS+1)-1:0] ov_addr,
   input  wire logic [63:0]                       ov_wdata,
   output logic      [63:0]                       ov_rdata
);
   localparam int IW = (IOAPIC_SLOTS > 1) ? $clog2(IOAPIC_SLOTS) : 1;
   localparam int OW = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
   logic [71:0] io_mem [IOAPIC_SLOTS];
   logic [63:0] ov_mem [OVERRIDE_SLOTS];
   logic [IW-1:0] io_a;
   logic [OW-1:0] ov_a;
   assign io_a = IW'(io_addr);
   assign ov_a = OW'(ov_addr);

   always_ff @(posedge clock) begin
      if (io_we) io_mem[io_a] <= io_wdata;
      io_rdata <= io_mem[io_a];
   end
   always_ff @(posedge clock) begin
      if (ov_we) ov_mem[ov_a] <= ov_wdata;
      ov_rdata <= ov_mem[ov_a];
   end
endmodule
`default_nettype wire

FILE: design/madt_interrupt_route_table.sv
`default_nettype none
// Channel  Dir  tuser        tdata, lowest bit first (padded to whole bytes)       tlast
// req_     in   opcode       data_byte, entry_index, isa_source (24 bits)          last
// rsp_     out  result_kind  found, owner, source_irq, words, tallies, addr (216)   -
// A table byte is accepted while idle and applied in the next cycle, in the byte state;
// a last byte then shows its summary from the output register. A route read goes through
// accept, memory read and result. The ISA lookup reads one stored override a cycle.
// Reset is synchronous and active high, empties the block and marks a fresh table;
// the route memories are not cleared, as slots are guarded by the fill counts.
// A waiting result in the output register holds rsp_ valid and blocks the next request.
module madt_interrupt_route_table #(
   parameter int IOAPIC_SLOTS = 8,
   parameter int OVERRIDE_SLOTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,  // opcode
   input  wire logic [23:0]  req_tdata,  // data_byte, entry_index, isa_source
   input  wire logic         req_tlast,  // last
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [1:0]        rsp_tuser,  // result_kind
   output logic [215:0]      rsp_tdata   // found, owner, src, a, b, counts, present, address
);
   import madt_pkg::*;
   localparam int ICW = $clog2(IOAPIC_SLOTS + 1);
   localparam int OCW = $clog2(OVERRIDE_SLOTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BYTE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [7:0]  byte_ff, isa_ff;
   logic        last_ff;
   logic [5:0]  idx_ff;
   logic        start_ff;
   summary_type sum_ff;
   logic [ICW-1:0] nio_ff;
   logic [OCW-1:0] nov_ff;
   logic [OCW-1:0] scan_ff;
   logic        found_ff;
   logic [7:0]  owner_ff, src_ff;
   logic [31:0] wa_ff, wb_ff;
   logic        ovalid_ff;

   logic        accept;
   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign accept = req_tvalid && req_tready;

   // Parser.
   logic        p_valid, p_done;
   logic [95:0] rb;
   logic [7:0]  rlen;
   assign p_valid = (state_ff == S_BYTE);
   madt_parser u_parser (
      .clock(clock), .reset(reset), .byte_valid(p_valid), .byte_data(byte_ff),
      .byte_last(last_ff), .clear(p_valid && start_ff), .rec_done(p_done),
      .rec_bytes(rb), .rec_len(rlen)
   );

   // Route memories.
   logic [ICW-1:0] io_addr;
   logic [OCW-1:0] ov_addr;
   logic           io_we, ov_we;
   logic [71:0]    io_rdata;
   logic [63:0]    ov_rdata;
   logic [7:0]     rtype;
   logic [ICW-1:0] nio_base;
   logic [OCW-1:0] nov_base;
   assign rtype = rb[7:0];
   assign nio_base = start_ff ? '0 : nio_ff;
   assign nov_base = start_ff ? '0 : nov_ff;
   assign io_we = p_done && rtype == REC_IO && rlen >= 8'd12
                  && nio_base < ICW'(IOAPIC_SLOTS);
   assign ov_we = p_done && rtype == REC_OVR && rlen >= 8'd10
                  && nov_base < OCW'(OVERRIDE_SLOTS);
   // While idle the memories are addressed from the offered beat, so that the
   // read data is ready in the cycle after acceptance.
   always_comb begin
      io_addr = ICW'(req_tdata[13:8]);
      ov_addr = (req_tuser == OP_ISA) ? '0 : OCW'(req_tdata[13:8]);
      if (state_ff == S_BYTE) begin
         io_addr = nio_base;
         ov_addr = nov_base;
      end else if (state_ff == S_SCAN) begin
         ov_addr = scan_ff;
      end
   end
   madt_route_store #(.IOAPIC_SLOTS(IOAPIC_SLOTS), .OVERRIDE_SLOTS(OVERRIDE_SLOTS)) u_store (
      .clock(clock),
      .io_we(io_we), .io_addr(io_addr), .io_wdata({rb[23:16], rb[63:32], rb[95:64]}),
      .io_rdata(io_rdata),
      .ov_we(ov_we), .ov_addr(ov_addr),
      .ov_wdata({rb[23:16], rb[31:24], rb[79:64], rb[63:32]}), .ov_rdata(ov_rdata)
   );

   // Record effects on the tallies.
   summary_type sum_base, sum_next;
   always_comb begin
      sum_base = start_ff ? '0 : sum_ff;
      sum_next = sum_base;
      if (p_done) begin
         case (rtype)
            REC_CPU: if (rlen >= 8'd8 && rb[33:32] != 2'b00)
               sum_next.cpu_total = sat_inc(sum_base.cpu_total);
            REC_IO: if (rlen >= 8'd12)
               sum_next.io_total = sat_inc(sum_base.io_total);
            REC_OVR: if (rlen >= 8'd10)
               sum_next.override_count = sat_inc(sum_base.override_count);
            REC_NMI, REC_LNMI:
               sum_next.nmi_total = sat_inc(sum_base.nmi_total);
            REC_LADDR: if (rlen >= 8'd12) begin
               sum_next.lapic_override_present = 1'b1;
               sum_next.lapic_override_address = rb[95:32];
            end
            default: ;
         endcase
      end
   end

   logic [OCW-1:0] scan_prev;
   logic           scan_hit;
   assign scan_prev = scan_ff - OCW'(1);
   assign scan_hit = ov_rdata[63:56] == 8'd0 && ov_rdata[55:48] == isa_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (req_tuser)
               OP_BYTE: state_in = S_BYTE;
               OP_ISA:  state_in = S_SCAN;
               default: state_in = S_RD;
            endcase
         end
         S_BYTE: state_in = S_IDLE;
         S_RD:   state_in = S_IDLE;
         S_SCAN: if ((scan_ff != '0 && scan_hit) || scan_ff == nov_ff
                     || scan_ff == OCW'(OVERRIDE_SLOTS)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b1;
         ovalid_ff <= 1'b0;
         sum_ff <= '0;
         nio_ff <= '0;
         nov_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ovalid_ff && rsp_tready) ovalid_ff <= 1'b0;
         if (state_ff == S_BYTE) begin
            sum_ff <= sum_next;
            nio_ff <= nio_base + ICW'(io_we);
            nov_ff <= nov_base + OCW'(ov_we);
            start_ff <= last_ff;
            if (last_ff) ovalid_ff <= 1'b1;
         end
         if (state_ff == S_RD || (state_ff == S_SCAN && state_in == S_IDLE))
            ovalid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_tuser;
         byte_ff <= req_tdata[7:0];
         idx_ff <= req_tdata[13:8];
         isa_ff <= req_tdata[21:14];
         last_ff <= req_tlast;
         scan_ff <= '0;
      end
      if (state_ff == S_SCAN) scan_ff <= scan_ff + OCW'(1);
      case (state_ff)
         S_BYTE: begin
            found_ff <= 1'b0; owner_ff <= '0; src_ff <= '0; wa_ff <= '0; wb_ff <= '0;
         end
         S_RD: begin
            if (op_ff == OP_IO_RD && {2'b0, idx_ff} < 8'(nio_ff)
                && {2'b0, idx_ff} < 8'(IOAPIC_SLOTS)) begin
               found_ff <= 1'b1;
               owner_ff <= io_rdata[71:64];
               src_ff <= '0;
               wa_ff <= io_rdata[63:32];
               wb_ff <= io_rdata[31:0];
            end else if (op_ff == OP_OVR_RD && {2'b0, idx_ff} < 8'(nov_ff)
                && {2'b0, idx_ff} < 8'(OVERRIDE_SLOTS)) begin
               found_ff <= 1'b1;
               owner_ff <= ov_rdata[63:56];
               src_ff <= ov_rdata[55:48];
               wb_ff <= {16'd0, ov_rdata[47:32]};
               wa_ff <= ov_rdata[31:0];
            end else begin
               found_ff <= 1'b0; owner_ff <= '0; src_ff <= '0; wa_ff <= '0; wb_ff <= '0;
            end
         end
         S_SCAN: begin
            // ov_rdata holds slot scan_ff - 1 once scan_ff is non-zero.
            if (scan_ff != '0 && scan_hit && scan_prev < nov_ff) begin
               found_ff <= 1'b1; owner_ff <= '0; src_ff <= isa_ff;
               wb_ff <= {16'd0, ov_rdata[47:32]};
               wa_ff <= ov_rdata[31:0];
            end else begin
               found_ff <= 1'b0; owner_ff <= '0; src_ff <= isa_ff;
               wa_ff <= {24'd0, isa_ff}; wb_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser = op_ff;
   assign rsp_tdata = {6'd0, sum_ff.lapic_override_address, sum_ff.lapic_override_present,
                       sum_ff.nmi_total, sum_ff.override_count, sum_ff.io_total,
                       sum_ff.cpu_total, wb_ff, wa_ff, src_ff, owner_ff, found_ff};
endmodule
`default_nettype wire

FILE: design/madt_checker.sv
`default_nettype none
`include "madt_interrupt_route_table_macros.svh"
module madt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [1:0]   rsp_tuser,
   input wire logic [215:0] rsp_tdata
);
   import madt_pkg::*;
   `MADT_ASSERT_IMPL(a_block, clock, reset, rsp_tvalid, !req_tready, "request taken while result waits")
   `MADT_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `MADT_ASSERT_IMPL(a_sum, clock, reset, rsp_tvalid && rsp_tuser == OP_BYTE, rsp_tdata[80:0] == 81'd0, "summary carries route data")
endmodule
bind madt_interrupt_route_table madt_checker u_chk (.*);
`default_nettype wire
